/* rtl/wvas_pkg.sv */
// Shared types and codes for the wind vane angle and sector block.
package wvas_pkg;

    localparam logic [1:0] REQ_MEASURE   = 2'd0;
    localparam logic [1:0] REQ_CAL_NORTH = 2'd1;
    localparam logic [1:0] REQ_CAL_SCALE = 2'd2;

    localparam logic [7:0] SETTLE_RESET = 8'd250;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic wrap;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

/* rtl/wvas_ctrl.sv */
// Sequencer for one word: capture, divide, wrap, deliver.
module wvas_ctrl
    import wvas_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_WRAP:
            begin
                cmd.wrap = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/wvas_dp.sv */
// Datapath: scaling divider, offset wrap, sector, calibration state and result register.
module wvas_dp
    import wvas_pkg::*;
#(
    parameter int SAMPLE_BITS     = 12,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int ANGLE_BITS      = 9 + ANGLE_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_data,
    input  logic [1:0]             req_type,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ANGLE_BITS-1:0]  angle,
    output logic [3:0]             sector,
    output logic                   over_range,
    output logic                   calib_done
);

    localparam int QW      = ANGLE_BITS;
    localparam int SB      = SAMPLE_BITS;
    localparam int DW      = SB + QW;
    localparam int CW      = $clog2(QW);
    localparam int FT_I    = 360 << ANGLE_FRAC_BITS;
    localparam int SPAN_I  = FT_I / 16;
    localparam int HALF_I  = FT_I / 32;
    localparam logic [QW-1:0] FULL_TURN = QW'(FT_I);
    localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

    logic [7:0]         settle_reg;
    logic [SB-1:0]      full_scale_reg;
    logic signed [QW:0] offset_reg;
    logic [SB-1:0]      cal_max_reg;
    logic [7:0]         cal_count_reg;
    logic               cal_active_reg;

    logic [1:0]         req_reg;
    logic [SB-1:0]      sample_reg;
    logic               over_reg;
    logic               zero_reg;
    logic [SB-1:0]      rem_reg;
    logic [QW-1:0]      dvd_reg;
    logic [QW-1:0]      quot_reg;
    logic [CW-1:0]      cnt_reg;
    logic [QW-1:0]      angle_reg;

    logic               out_valid_reg;
    logic [QW-1:0]      angle_out_reg;
    logic [3:0]         sector_out_reg;
    logic               over_out_reg;
    logic               done_out_reg;

    logic [DW-1:0]      prod;
    logic [SB:0]        trial;
    logic               trial_ge;
    logic [QW-1:0]      raw;
    logic signed [QW+1:0] wsum;
    logic signed [QW+1:0] wadj;
    logic [3:0]         sector_next;

    logic [SB-1:0]      cm;
    logic [7:0]         cc;
    logic [8:0]         cnext;

    assign prod     = DW'(sample) * DW'(FULL_TURN);
    assign trial    = {rem_reg, dvd_reg[QW-1]};
    assign trial_ge = trial >= {1'b0, full_scale_reg};
    assign raw      = (over_reg || zero_reg) ? '0 : quot_reg;

    assign wsum = $signed({2'b00, raw}) + $signed({offset_reg[QW], offset_reg});

    always_comb
    begin
        wadj = wsum;
        if (wsum >= $signed({2'b00, FULL_TURN}))
        begin
            wadj = wsum - $signed({2'b00, FULL_TURN});
        end
        else if (wsum < 0)
        begin
            wadj = wsum + $signed({2'b00, FULL_TURN});
        end
    end

    always_comb
    begin
        logic [QW:0] thr;
        sector_next = '0;
        for (int k = 1; k <= 16; k++)
        begin
            thr = (QW + 1)'(k * SPAN_I - HALF_I);
            if ({1'b0, angle_reg} >= thr)
            begin
                sector_next = 4'(k);
            end
        end
    end

    always_comb
    begin
        cm    = cal_active_reg ? cal_max_reg : '0;
        cc    = cal_active_reg ? cal_count_reg : '0;
        if (sample_reg > cm)
        begin
            cm = sample_reg;
        end
        cnext = {1'b0, cc} + 9'd1;
    end

    assign status.div_last = cnt_reg == LAST_STEP;
    assign status.out_free = !out_valid_reg || out_ready;

    // Control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg     <= SETTLE_RESET;
            full_scale_reg <= '1;
            offset_reg     <= '0;
            cal_max_reg    <= '0;
            cal_count_reg  <= '0;
            cal_active_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                settle_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (req_reg == REQ_CAL_NORTH)
                begin
                    offset_reg <= $signed((QW + 1)'(0) - {1'b0, raw});
                end
                else if (req_reg == REQ_CAL_SCALE)
                begin
                    if (sample_reg < cm)
                    begin
                        if (cnext > {1'b0, settle_reg})
                        begin
                            full_scale_reg <= cm;
                            cal_max_reg    <= '0;
                            cal_count_reg  <= '0;
                            cal_active_reg <= 1'b0;
                        end
                        else
                        begin
                            cal_max_reg    <= cm;
                            cal_count_reg  <= cnext[7:0];
                            cal_active_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        cal_max_reg    <= cm;
                        cal_count_reg  <= '0;
                        cal_active_reg <= 1'b1;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            sample_reg <= sample;
            over_reg   <= sample > full_scale_reg;
            zero_reg   <= full_scale_reg == '0;
            rem_reg    <= prod[DW-1:QW];
            dvd_reg    <= prod[QW-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg  <= trial_ge ? SB'(trial - {1'b0, full_scale_reg}) : trial[SB-1:0];
            dvd_reg  <= {dvd_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], trial_ge};
        end
        if (cmd.wrap)
        begin
            angle_reg <= (req_reg == REQ_MEASURE && !over_reg) ? wadj[QW-1:0] : '0;
        end
        if (cmd.finish)
        begin
            angle_out_reg  <= angle_reg;
            sector_out_reg <= (req_reg == REQ_MEASURE && sector_next != 4'd0
                               && !({1'b0, angle_reg} >= (QW + 1)'(16 * SPAN_I - HALF_I)))
                              ? sector_next : 4'd0;
            over_out_reg   <= (req_reg == REQ_MEASURE || req_reg == REQ_CAL_NORTH) && over_reg;
            done_out_reg   <= req_reg == REQ_CAL_SCALE && sample_reg < cm
                              && cnext > {1'b0, settle_reg};
        end
    end

    assign out_valid  = out_valid_reg;
    assign angle      = angle_out_reg;
    assign sector     = sector_out_reg;
    assign over_range = over_out_reg;
    assign calib_done = done_out_reg;

endmodule

/* rtl/wind_vane_angle_and_sector.sv */
// Top level of the wind vane angle and sector block.
//
// Input channel: in_valid/in_ready carry one word of req_type and sample.
// Output channel: out_valid/out_ready carry one word of angle, sector,
// over_range and calib_done for every input word, in order.
// Configuration: cfg_we writes cfg_data into settle_count at once.
//
// A word is taken in the idle cycle, then a restoring divider by the
// stored full scale runs one quotient bit per cycle (9 + ANGLE_FRAC_BITS
// quotient bits), then the wrap state adds and wraps the north offset and
// the done state forms the sector and loads the result register once it
// is free. A new word is accepted only after the previous word has loaded
// the result register.
// A result waiting in the output register does not block the next word;
// that word is held at its last step until the register is free.
//
// Reset empties the result register, sets full scale to all ones,
// clears the north offset and calibration, and sets settle_count to 250.
module wind_vane_angle_and_sector
    import wvas_pkg::*;
#(
    parameter int SAMPLE_BITS     = 12,
    parameter int ANGLE_FRAC_BITS = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [SAMPLE_BITS-1:0]       sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [8+ANGLE_FRAC_BITS:0]   angle,
    output logic [3:0]                   sector,
    output logic                         over_range,
    output logic                         calib_done
);

    cmd_t    cmd;
    status_t status;

    wvas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wvas_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .ANGLE_BITS      (9 + ANGLE_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .sample     (sample),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .angle      (angle),
        .sector     (sector),
        .over_range (over_range),
        .calib_done (calib_done)
    );

endmodule
